// ----- rtl/ppwm_pkg.sv -----
// ============================================================================
// ppwm_pkg
// Shared types and constants for the packet payload word matcher: command
// codes, layer-4 protocol kinds and the header offsets used by the parser.
// ============================================================================
package ppwm_pkg;

    // Transaction command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // Layer-4 protocol seen in the current frame
    typedef enum logic [1:0] {
        PROTO_NONE,
        PROTO_TCP,
        PROTO_UDP
    } t_proto;

    // Frame byte offsets
    localparam logic [15:0] OFS_ETYPE_HI = 16'd12;
    localparam logic [15:0] OFS_ETYPE_LO = 16'd13;
    localparam logic [15:0] OFS_IP_IHL   = 16'd14;
    localparam logic [15:0] OFS_IP_PROTO = 16'd23;
    localparam logic [15:0] FRAME_OFS_MAX = 16'hFFFF;

    // Header lengths and field positions
    localparam logic [7:0] ETH_HDR_LEN  = 8'd14;
    localparam logic [7:0] UDP_HDR_LEN  = 8'd8;
    localparam logic [7:0] TCP_DOFF_OFS = 8'd12;
    localparam logic [7:0] UDP_PAY_MIN  = 8'd24;

    // Field values and masks
    localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0] IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0] IP_PROTO_UDP  = 8'd17;
    localparam logic [7:0] IHL_MASK      = 8'h0F;
    localparam logic [7:0] DOFF_MASK     = 8'hF0;

endpackage

// ----- rtl/packet_payload_word_matcher_unit.sv -----
// ============================================================================
// packet_payload_word_matcher_unit
// Loads up to NUM_WORDS search words, parses Ethernet/IPv4/TCP-UDP frames
// byte by byte and flags each word the first time it appears in a payload.
// ============================================================================
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | i_cfg_valid / o_cfg_ready, i_cfg_word_count| in
//  in      | i_in_valid / o_in_ready, cmd .. frame_last | in
//  out     | o_out_valid / i_out_ready, result fields   | out
//
//  One transaction per cycle while the result is not stalled. An input
//  transaction is held in the input register; the parse, the parallel window
//  compare and the match update then act combinationally into the result register.
//  A frame byte yields one result transaction, a load transaction none.
//  A stalled result holds the work stage; the input register still takes
//  a transaction while it is empty. Reset is synchronous; no clearing pass.
//
module packet_payload_word_matcher_unit #(
    parameter int NUM_WORDS = 8,
    parameter int WORD_MAX  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_word_count,
    // input items
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic [2:0] i_word_index,
    input  logic [3:0] i_char_index,
    input  logic       i_word_end,
    input  logic       i_frame_last,
    // results
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_new_matches,
    output logic [3:0] o_matched_total,
    output logic       o_all_matched
);

    localparam int LEN_W = $clog2(WORD_MAX + 1);
    localparam int CNT_W = $clog2(NUM_WORDS + 1);
    localparam int WIN_D = WORD_MAX - 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]           r_word_count;

    logic                 r_in_valid;
    logic                 r_in_cmd;
    logic [7:0]           r_in_byte;
    logic [2:0]           r_in_word_idx;
    logic [3:0]           r_in_char_idx;
    logic                 r_in_word_end;
    logic                 r_in_last;

    logic [7:0]           r_pat [NUM_WORDS][WORD_MAX];
    logic [LEN_W-1:0]     r_len [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_flags;
    logic [CNT_W-1:0]     r_match_count;

    logic [7:0]           r_win [WIN_D];
    logic [15:0]          r_frame_ofs;
    logic [7:0]           r_pay_ofs;
    logic [LEN_W-1:0]     r_seen;
    logic                 r_skip;
    logic [7:0]           r_l4_start;
    ppwm_pkg::t_proto     r_proto;
    logic                 r_pay_known;

    logic                 r_out_valid;
    logic [7:0]           r_out_new;
    logic [3:0]           r_out_total;
    logic                 r_out_all;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic fire;
    logic is_load;
    logic is_frame;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign is_load    = fire && (r_in_cmd == ppwm_pkg::CMD_LOAD);
    assign is_frame   = fire && (r_in_cmd == ppwm_pkg::CMD_FRAME);

    // ------------------------------------------------------------------
    // Header parse: next frame state and scan decision
    // ------------------------------------------------------------------
    logic             n_skip;
    logic [7:0]       n_l4_start;
    ppwm_pkg::t_proto n_proto;
    logic [7:0]       n_pay_ofs;
    logic             n_pay_known;
    logic             do_scan;

    always_comb begin
        logic [7:0] start;
        logic [7:0] floor_ofs;
        n_skip      = r_skip;
        n_l4_start  = r_l4_start;
        n_proto     = r_proto;
        n_pay_ofs   = r_pay_ofs;
        n_pay_known = r_pay_known;
        do_scan     = 1'b0;
        start       = '0;
        floor_ofs   = '0;
        if (!r_skip) begin
            if (r_frame_ofs == ppwm_pkg::OFS_ETYPE_HI &&
                r_in_byte != ppwm_pkg::ETYPE_IPV4_HI) begin
                n_skip = 1'b1;
            end else if (r_frame_ofs == ppwm_pkg::OFS_ETYPE_LO &&
                         r_in_byte != ppwm_pkg::ETYPE_IPV4_LO) begin
                n_skip = 1'b1;
            end else if (r_frame_ofs == ppwm_pkg::OFS_IP_IHL) begin
                n_l4_start = ppwm_pkg::ETH_HDR_LEN + ((r_in_byte & ppwm_pkg::IHL_MASK) << 2);
            end else if (r_frame_ofs == ppwm_pkg::OFS_IP_PROTO) begin
                if (r_in_byte == ppwm_pkg::IP_PROTO_TCP) begin
                    n_proto = ppwm_pkg::PROTO_TCP;
                end else if (r_in_byte == ppwm_pkg::IP_PROTO_UDP) begin
                    // payload after the 8-byte UDP header, never before the next byte
                    start       = r_l4_start + ppwm_pkg::UDP_HDR_LEN;
                    n_proto     = ppwm_pkg::PROTO_UDP;
                    n_pay_ofs   = (start < ppwm_pkg::UDP_PAY_MIN) ? ppwm_pkg::UDP_PAY_MIN : start;
                    n_pay_known = 1'b1;
                end else begin
                    n_skip = 1'b1;
                end
            end
            // TCP data offset byte: payload after the TCP header
            if (!n_skip && n_proto == ppwm_pkg::PROTO_TCP && !n_pay_known &&
                r_frame_ofs == 16'(n_l4_start) + 16'(ppwm_pkg::TCP_DOFF_OFS)) begin
                start       = n_l4_start + ((r_in_byte & ppwm_pkg::DOFF_MASK) >> 2);
                floor_ofs   = n_l4_start + ppwm_pkg::TCP_DOFF_OFS + 8'd1;
                n_pay_ofs   = (start < floor_ofs) ? floor_ofs : start;
                n_pay_known = 1'b1;
            end
            do_scan = !n_skip && n_pay_known && (r_frame_ofs >= 16'(n_pay_ofs));
        end
    end

    // ------------------------------------------------------------------
    // Window compare: every word against every length in parallel
    // ------------------------------------------------------------------
    logic [7:0]           tap [WORD_MAX];
    logic [LEN_W-1:0]     seen_inc;
    logic [CNT_W-1:0]     words_used;
    logic [NUM_WORDS-1:0] fresh;
    logic [CNT_W-1:0]     fresh_cnt;
    logic [NUM_WORDS-1:0] n_flags;
    logic [CNT_W-1:0]     n_match_count;

    always_comb begin
        tap[0] = r_in_byte;
        for (int k = 1; k < WORD_MAX; k++) begin
            tap[k] = r_win[k-1];
        end
    end

    assign seen_inc   = (r_seen < LEN_W'(WORD_MAX)) ? r_seen + LEN_W'(1) : r_seen;
    assign words_used = (r_word_count > NUM_WORDS) ? CNT_W'(NUM_WORDS) : CNT_W'(r_word_count);

    always_comb begin
        logic [WORD_MAX:1] len_eq;
        logic              hit;
        for (int w = 0; w < NUM_WORDS; w++) begin
            // word ending at this byte, one candidate per length
            for (int l = 1; l <= WORD_MAX; l++) begin
                len_eq[l] = 1'b1;
                for (int k = 0; k < l; k++) begin
                    len_eq[l] = len_eq[l] && (r_pat[w][l-1-k] == tap[k]);
                end
            end
            hit = 1'b0;
            for (int l = 1; l <= WORD_MAX; l++) begin
                if (r_len[w] == LEN_W'(l)) begin
                    hit = len_eq[l];
                end
            end
            fresh[w] = do_scan && hit && !r_flags[w] && (w < int'(words_used)) &&
                       (r_len[w] != '0) && (r_len[w] <= seen_inc);
        end
    end

    // count this byte's first finds
    always_comb begin
        fresh_cnt = '0;
        for (int w = 0; w < NUM_WORDS; w++) begin
            fresh_cnt = fresh_cnt + CNT_W'(fresh[w]);
        end
    end

    assign n_flags       = r_flags | fresh;
    assign n_match_count = r_match_count + fresh_cnt;

    logic [NUM_WORDS+7:0] new_ext;
    logic [CNT_W+3:0]     total_ext;

    assign new_ext   = {8'b0, fresh};
    assign total_ext = {4'b0, n_match_count};

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count  <= 4'd1;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_flags       <= '0;
            r_match_count <= '0;
            r_frame_ofs   <= '0;
            r_pay_ofs     <= '0;
            r_seen        <= '0;
            r_skip        <= 1'b0;
            r_l4_start    <= '0;
            r_proto       <= ppwm_pkg::PROTO_NONE;
            r_pay_known   <= 1'b0;
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_len[w] <= '0;
            end
        end else begin
            // configuration write
            if (i_cfg_valid) begin
                r_word_count <= i_cfg_word_count;
            end
            // input register occupancy
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            // result register occupancy
            if (is_frame) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // load: set length, drop match progress
            if (is_load) begin
                r_flags       <= '0;
                r_match_count <= '0;
                for (int w = 0; w < NUM_WORDS; w++) begin
                    if (int'(r_in_word_idx) == w && int'(r_in_char_idx) < WORD_MAX &&
                        r_in_word_end) begin
                        r_len[w] <= LEN_W'({1'b0, r_in_char_idx} + 5'd1);
                    end
                end
            end
            // frame byte: advance parser, record finds
            if (is_frame) begin
                r_flags       <= n_flags;
                r_match_count <= n_match_count;
                if (r_in_last) begin
                    r_frame_ofs <= '0;
                    r_pay_ofs   <= '0;
                    r_seen      <= '0;
                    r_skip      <= 1'b0;
                    r_l4_start  <= '0;
                    r_proto     <= ppwm_pkg::PROTO_NONE;
                    r_pay_known <= 1'b0;
                end else begin
                    if (r_frame_ofs != ppwm_pkg::FRAME_OFS_MAX) begin
                        r_frame_ofs <= r_frame_ofs + 16'd1;
                    end
                    if (do_scan) begin
                        r_seen <= seen_inc;
                    end
                    r_pay_ofs   <= n_pay_ofs;
                    r_skip      <= n_skip;
                    r_l4_start  <= n_l4_start;
                    r_proto     <= n_proto;
                    r_pay_known <= n_pay_known;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // capture the input transaction
        if (i_in_valid && o_in_ready) begin
            r_in_cmd      <= i_cmd;
            r_in_byte     <= i_data_byte;
            r_in_word_idx <= i_word_index;
            r_in_char_idx <= i_char_index;
            r_in_word_end <= i_word_end;
            r_in_last     <= i_frame_last;
        end
        // write one pattern character
        if (is_load) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                for (int j = 0; j < WORD_MAX; j++) begin
                    if (int'(r_in_word_idx) == w && int'(r_in_char_idx) == j) begin
                        r_pat[w][j] <= r_in_byte;
                    end
                end
            end
        end
        // shift the payload window; stale bytes are masked by the seen count
        if (is_frame && do_scan) begin
            r_win[0] <= r_in_byte;
            for (int k = 1; k < WIN_D; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
        // hold the result
        if (is_frame) begin
            r_out_new   <= new_ext[7:0];
            r_out_total <= total_ext[3:0];
            r_out_all   <= (n_match_count >= words_used);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_new_matches   = r_out_new;
    assign o_matched_total = r_out_total;
    assign o_all_matched   = r_out_all;

`ifndef NO_ASSERTIONS
    // a load transaction always leaves the match progress empty
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_load |=> (r_match_count == '0 && r_flags == '0))
        else $error("match progress not cleared by load");

    // the matched total tracks the match mask
    a_count_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_match_count) == $countones(r_flags))
        else $error("match count differs from match mask");

    // a known payload start implies a recognized layer-4 protocol
    a_pay_proto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_known |-> (r_proto == ppwm_pkg::PROTO_TCP || r_proto == ppwm_pkg::PROTO_UDP))
        else $error("payload start known without protocol");
`endif

endmodule

// ----- test/tb_packet_payload_word_matcher_unit.sv -----
// ============================================================================
// tb_packet_payload_word_matcher_unit
// Self-checking bench for the payload word matcher. Loads search words,
// streams well-formed and broken Ethernet/IPv4/TCP-UDP frames with embedded
// word copies, and compares every result transaction against a predictor
// that tracks the same parse, window and match state.
// ============================================================================
module tb_packet_payload_word_matcher_unit;

    localparam int NWORDS        = 8;
    localparam int WMAX          = 16;
    localparam int TAIL_CYCLES   = 8;
    localparam int PHASE_ITEMS   = 375;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int ERR_PRINT_MAX = 30;
    // frame kinds: noise, bad ethertype high/low, other protocol,
    // odd header nibbles, TCP, UDP, truncated before the payload
    localparam int KIND_BAD_HI   = 5;
    localparam int KIND_BAD_LO   = 9;
    localparam int KIND_BAD_PROT = 13;
    localparam int KIND_ODD_NIB  = 18;
    localparam int KIND_TCP      = 26;
    localparam int KIND_UDP      = 61;
    localparam int KIND_SHORT    = 90;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic [2:0] word_index;
        logic [3:0] char_index;
        logic       word_end;
        logic       frame_last;
    } t_pkt_item;

    typedef struct packed {
        logic [7:0] new_matches;
        logic [3:0] matched_total;
        logic       all_matched;
    } t_match_result;

    // ------------------------------------------------------------------------
    // Match predictor and store of expected results
    // ------------------------------------------------------------------------
    class match_scoreboard;
        logic [7:0]       pat_chars [NWORDS][WMAX];
        logic [4:0]       pat_len   [NWORDS];
        logic [7:0]       found_mask;
        logic [3:0]       found_count;
        logic [7:0]       recent    [WMAX-1];
        logic [15:0]      frame_pos;
        int               pay_start;
        logic [4:0]       pay_depth;
        bit               skip_frame;
        logic [3:0]       words_cfg;
        int               l4_ofs;
        ppwm_pkg::t_proto proto;
        bit               pay_known;
        t_match_result    expected_matches [$];
        int               errors;

        function new();
            foreach (pat_chars[w, c]) pat_chars[w][c] = '0;
            foreach (pat_len[w]) pat_len[w] = '0;
            found_mask  = '0;
            found_count = '0;
            words_cfg   = 4'd1;
            errors      = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (recent[k]) recent[k] = '0;
            frame_pos  = '0;
            pay_start  = 0;
            pay_depth  = '0;
            skip_frame = 1'b0;
            l4_ofs     = 0;
            proto      = ppwm_pkg::PROTO_NONE;
            pay_known  = 1'b0;
        endfunction

        function void set_word_count(logic [3:0] v);
            words_cfg = v;
        endfunction

        function int words_used();
            return (words_cfg > NWORDS) ? NWORDS : int'(words_cfg);
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        function bit count_failure();
            errors++;
            return errors <= ERR_PRINT_MAX;
        endfunction

        // Shift one payload byte into the window and compare every live word
        function logic [7:0] scan_payload(logic [7:0] b);
            logic [7:0] fresh;
            logic [7:0] tail [WMAX];
            int         len;
            bit         hit;
            fresh = '0;
            if (pay_depth < WMAX) pay_depth++;
            tail[0] = b;
            for (int k = 1; k < WMAX; k++) tail[k] = recent[k-1];
            for (int w = 0; w < words_used(); w++) begin
                len = pat_len[w];
                if (len == 0 || len > pay_depth || found_mask[w]) continue;
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (pat_chars[w][len-1-k] != tail[k]) hit = 1'b0;
                if (hit) begin
                    found_mask[w] = 1'b1;
                    found_count++;
                    fresh[w] = 1'b1;
                end
            end
            for (int k = WMAX - 2; k > 0; k--) recent[k] = recent[k-1];
            recent[0] = b;
            return fresh;
        endfunction

        // Advance the predictor by one accepted input transaction
        function void note_item(t_pkt_item it);
            int            pos;
            int            s;
            logic [7:0]    b;
            t_match_result r;
            if (it.cmd == ppwm_pkg::CMD_LOAD) begin
                found_mask  = '0;
                found_count = '0;
                pat_chars[it.word_index][it.char_index] = it.data_byte;
                if (it.word_end) pat_len[it.word_index] = 5'(it.char_index) + 5'd1;
                return;
            end
            b   = it.data_byte;
            pos = int'(frame_pos);
            r.new_matches = '0;
            if (!skip_frame) begin
                if (pos == ppwm_pkg::OFS_ETYPE_HI && b != ppwm_pkg::ETYPE_IPV4_HI)
                    skip_frame = 1'b1;
                else if (pos == ppwm_pkg::OFS_ETYPE_LO && b != ppwm_pkg::ETYPE_IPV4_LO)
                    skip_frame = 1'b1;
                else if (pos == ppwm_pkg::OFS_IP_IHL)
                    l4_ofs = ppwm_pkg::ETH_HDR_LEN + (b & ppwm_pkg::IHL_MASK) * 4;
                else if (pos == ppwm_pkg::OFS_IP_PROTO) begin
                    if (b == ppwm_pkg::IP_PROTO_TCP) begin
                        proto = ppwm_pkg::PROTO_TCP;
                    end else if (b == ppwm_pkg::IP_PROTO_UDP) begin
                        proto     = ppwm_pkg::PROTO_UDP;
                        s         = l4_ofs + ppwm_pkg::UDP_HDR_LEN;
                        pay_start = (s < pos + 1) ? pos + 1 : s;
                        pay_known = 1'b1;
                    end else begin
                        skip_frame = 1'b1;
                    end
                end
                // TCP payload start comes from the data-offset nibble
                if (!skip_frame && proto == ppwm_pkg::PROTO_TCP && !pay_known &&
                    pos == l4_ofs + ppwm_pkg::TCP_DOFF_OFS) begin
                    s         = l4_ofs + ((b & ppwm_pkg::DOFF_MASK) >> 4) * 4;
                    pay_start = (s < pos + 1) ? pos + 1 : s;
                    pay_known = 1'b1;
                end
                if (!skip_frame && pay_known && pos >= pay_start)
                    r.new_matches = scan_payload(b);
            end
            if (frame_pos != ppwm_pkg::FRAME_OFS_MAX) frame_pos++;
            if (it.frame_last) clear_frame();
            r.matched_total = found_count;
            r.all_matched   = (found_count >= words_used());
            expected_matches.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got && count_failure())
                $error("%s mismatch: expected %h, actual %h", name, want, got);
        endfunction

        // Compare one accepted result transaction with the oldest expectation
        function void check_result(t_match_result got);
            t_match_result want;
            if (expected_matches.size() == 0) begin
                if (count_failure())
                    $error("unexpected result: new_matches %h matched_total %h all_matched %b",
                           got.new_matches, got.matched_total, got.all_matched);
                return;
            end
            want = expected_matches.pop_front();
            compare_field("new_matches", want.new_matches, got.new_matches);
            compare_field("matched_total", 8'(want.matched_total), 8'(got.matched_total));
            compare_field("all_matched", 8'(want.all_matched), 8'(got.all_matched));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and signals
    // ------------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_word_count;
    logic       i_in_valid;
    logic       o_in_ready;
    logic       i_cmd;
    logic [7:0] i_data_byte;
    logic [2:0] i_word_index;
    logic [3:0] i_char_index;
    logic       i_word_end;
    logic       i_frame_last;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_new_matches;
    logic [3:0] o_matched_total;
    logic       o_all_matched;

    t_match_result   dut_result;
    match_scoreboard sb;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int gap_plan   [4] = '{0, 49, 0, 28};
    int stall_plan [4] = '{0, 0, 49, 28};
    int count_plan [4] = '{8, 15, 4, 1};

    // stimulus-side copy of the loaded words, used to plant copies in payloads
    logic [7:0] word_chars  [NWORDS][WMAX];
    bit         char_loaded [NWORDS][WMAX];
    int         word_len    [NWORDS];
    logic [7:0] frame_bytes [$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    packet_payload_word_matcher_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_word_count (i_cfg_word_count),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .i_word_index     (i_word_index),
        .i_char_index     (i_char_index),
        .i_word_end       (i_word_end),
        .i_frame_last     (i_frame_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_new_matches    (o_new_matches),
        .o_matched_total  (o_matched_total),
        .o_all_matched    (o_all_matched)
    );

    assign dut_result = {o_new_matches, o_matched_total, o_all_matched};

    // Randomly stall the result channel
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check each result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(dut_result);
    end

    // Abort when no channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("packet_payload_word_matcher_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_byte(bit narrow);
        return narrow ? 8'(8'h61 + $urandom_range(3)) : 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] byte_other_than(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        do r = 8'($urandom_range(255)); while (r == a || r == b);
        return r;
    endfunction

    // Present one input transaction, with random gaps, and hold until taken
    task automatic send_item(input t_pkt_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= it.cmd;
        i_data_byte  <= it.data_byte;
        i_word_index <= it.word_index;
        i_char_index <= it.char_index;
        i_word_end   <= it.word_end;
        i_frame_last <= it.frame_last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] d, input bit last);
        t_pkt_item it;
        it.cmd        = ppwm_pkg::CMD_FRAME;
        it.data_byte  = d;
        it.word_index = 3'($urandom_range(7));
        it.char_index = 4'($urandom_range(15));
        it.word_end   = 1'($urandom_range(1));
        it.frame_last = last;
        send_item(it);
    endtask

    task automatic load_char(input int w, input int c, input logic [7:0] d, input bit last);
        t_pkt_item it;
        it.cmd        = ppwm_pkg::CMD_LOAD;
        it.data_byte  = d;
        it.word_index = w[2:0];
        it.char_index = c[3:0];
        it.word_end   = last;
        it.frame_last = 1'($urandom_range(1));
        word_chars[w][c]  = d;
        char_loaded[w][c] = 1'b1;
        if (last) word_len[w] = c + 1;
        send_item(it);
    endtask

    task automatic load_word(input int w);
        int len;
        bit narrow;
        case ($urandom_range(7))
            0:       len = WMAX;
            1:       len = $urandom_range(7, WMAX - 1);
            default: len = $urandom_range(1, 6);
        endcase
        narrow = ($urandom_range(3) != 0);
        for (int c = 0; c < len; c++) load_char(w, c, pick_byte(narrow), c == len - 1);
    endtask

    // Stray load: rewrite one character; end the word only over loaded characters
    task automatic stray_load();
        int w;
        int c;
        bit all_set;
        w = $urandom_range(NWORDS - 1);
        c = $urandom_range(WMAX - 1);
        all_set = 1'b1;
        for (int k = 0; k < c; k++) if (!char_loaded[w][k]) all_set = 1'b0;
        load_char(w, c, pick_byte(1'($urandom_range(1))),
                  all_set && $urandom_range(3) == 0);
    endtask

    // Append payload bytes, planting copies of loaded words now and then
    task automatic append_payload(input int len, input bit narrow);
        int stop;
        int w;
        stop = frame_bytes.size() + len;
        while (frame_bytes.size() < stop) begin
            w = $urandom_range(NWORDS - 1);
            if ($urandom_range(7) == 0 && word_len[w] > 0)
                for (int k = 0; k < word_len[w]; k++) frame_bytes.push_back(word_chars[w][k]);
            else
                frame_bytes.push_back(pick_byte(narrow));
        end
    endtask

    task automatic build_frame(input int force_kind, input int pay_len);
        int kind;
        int ihl;
        int doff;
        int l4;
        int pay_at;
        bit narrow;
        bit is_tcp;
        frame_bytes.delete();
        kind   = (force_kind >= 0) ? force_kind : $urandom_range(99);
        narrow = 1'($urandom_range(1));
        // raw noise
        if (kind < KIND_BAD_HI) begin
            repeat ($urandom_range(1, 60)) frame_bytes.push_back(pick_byte(narrow));
            return;
        end
        is_tcp = (kind >= KIND_TCP && kind < KIND_UDP) ? 1'b1 :
                 (kind >= KIND_UDP && kind < KIND_SHORT) ? 1'b0 : 1'($urandom_range(1));
        repeat (12) frame_bytes.push_back(pick_byte(narrow));
        frame_bytes.push_back((kind >= KIND_BAD_HI && kind < KIND_BAD_LO) ?
            byte_other_than(ppwm_pkg::ETYPE_IPV4_HI, ppwm_pkg::ETYPE_IPV4_HI) :
            ppwm_pkg::ETYPE_IPV4_HI);
        frame_bytes.push_back((kind >= KIND_BAD_LO && kind < KIND_BAD_PROT) ?
            byte_other_than(ppwm_pkg::ETYPE_IPV4_LO, ppwm_pkg::ETYPE_IPV4_LO) :
            ppwm_pkg::ETYPE_IPV4_LO);
        if (kind >= KIND_ODD_NIB && kind < KIND_TCP) begin
            ihl  = $urandom_range(15);
            doff = $urandom_range(15);
        end else begin
            ihl  = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
            doff = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
        end
        frame_bytes.push_back({4'($urandom_range(15)), 4'(ihl)});
        repeat (8) frame_bytes.push_back(pick_byte(narrow));
        if (kind >= KIND_BAD_PROT && kind < KIND_ODD_NIB)
            frame_bytes.push_back(byte_other_than(ppwm_pkg::IP_PROTO_TCP,
                                                  ppwm_pkg::IP_PROTO_UDP));
        else
            frame_bytes.push_back(is_tcp ? ppwm_pkg::IP_PROTO_TCP : ppwm_pkg::IP_PROTO_UDP);
        l4 = ppwm_pkg::ETH_HDR_LEN + ihl * 4;
        while (frame_bytes.size() < l4) frame_bytes.push_back(pick_byte(narrow));
        if (is_tcp) begin
            while (frame_bytes.size() < l4 + ppwm_pkg::TCP_DOFF_OFS)
                frame_bytes.push_back(pick_byte(narrow));
            frame_bytes.push_back({4'(doff), 4'($urandom_range(15))});
            pay_at = (l4 + doff * 4 > l4 + ppwm_pkg::TCP_DOFF_OFS + 1) ?
                     l4 + doff * 4 : l4 + ppwm_pkg::TCP_DOFF_OFS + 1;
        end else begin
            pay_at = (l4 + ppwm_pkg::UDP_HDR_LEN > ppwm_pkg::UDP_PAY_MIN) ?
                     l4 + ppwm_pkg::UDP_HDR_LEN : ppwm_pkg::UDP_PAY_MIN;
        end
        while (frame_bytes.size() < pay_at) frame_bytes.push_back(pick_byte(narrow));
        // cut the frame before its payload
        if (kind >= KIND_SHORT) begin
            pay_at = $urandom_range(1, pay_at);
            while (frame_bytes.size() > pay_at) void'(frame_bytes.pop_back());
            return;
        end
        if (pay_len < 0)
            pay_len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
        append_payload(pay_len, narrow);
    endtask

    // Stream the built frame, with an occasional load in the middle
    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if ($urandom_range(199) == 0) stray_load();
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Hold the sender until every result is back, then let the pipe empty
    task automatic settle_block(input int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_word_count(input logic [3:0] v);
        i_cfg_valid      <= 1'b1;
        i_cfg_word_count <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_word_count(v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [3:0] pick_word_count();
        case ($urandom_range(9))
            0:       return 4'd0;
            1:       return 4'd15;
            2:       return 4'($urandom_range(9, 14));
            default: return 4'($urandom_range(1, NWORDS));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int  pick;
        int  phase_base;
        bit  paused;
        sb = new();
        foreach (char_loaded[w, c]) char_loaded[w][c] = 1'b0;
        foreach (word_len[w]) word_len[w] = 0;
        i_rst_n          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_word_count <= '0;
        i_in_valid       <= 1'b0;
        i_cmd            <= ppwm_pkg::CMD_FRAME;
        i_data_byte      <= '0;
        i_word_index     <= '0;
        i_char_index     <= '0;
        i_word_end       <= 1'b0;
        i_frame_last     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-byte frame while every word is still empty
        send_byte(8'hFF, 1'b1);
        load_char(NWORDS - 1, WMAX - 1, 8'hFF, 1'b0);
        load_char(0, 0, 8'h00, 1'b1);
        // header cut right after the ethertype: nothing searched
        for (int i = 0; i < 14; i++)
            send_byte((i == 12) ? ppwm_pkg::ETYPE_IPV4_HI : 8'h00, i == 13);
        // no word in use: all matched from the start
        settle_block(TAIL_CYCLES);
        write_word_count(4'd0);
        send_byte(8'h00, 1'b1);
        // count above the number of words acts as all words
        settle_block(TAIL_CYCLES);
        write_word_count(4'd15);
        send_byte(8'h00, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            settle_block(TAIL_CYCLES);
            send_gap_pct = gap_plan[ph];
            stall_pct    = stall_plan[ph];
            write_word_count(4'(count_plan[ph]));
            for (int w = 0; w < NWORDS; w++) load_word(w);
            phase_base = items_sent;
            paused     = 1'b0;
            while (items_sent - phase_base < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    load_word($urandom_range(NWORDS - 1));
                end else if (pick < 9) begin
                    settle_block(TAIL_CYCLES);
                    write_word_count(pick_word_count());
                end else begin
                    build_frame(-1, -1);
                    send_frame();
                end
                if (!paused && items_sent - phase_base >= PHASE_ITEMS / 2) begin
                    settle_block(0);
                    paused = 1'b1;
                end
            end
        end

        settle_block(TAIL_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("packet_payload_word_matcher_unit verification clean");
        else
            $display("packet_payload_word_matcher_unit verification failed");
        $finish;
    end

endmodule

// ----- packet_payload_word_matcher_unit.f -----
rtl/ppwm_pkg.sv
rtl/packet_payload_word_matcher_unit.sv
test/tb_packet_payload_word_matcher_unit.sv
